FILE: rtl/hic_pkg.sv
// ----------------------------------------------------------------------------
// hic_pkg: shared types and constants
// Register indexes, register reset values and the configuration bundle that
// the curve walk and the scaling stages read.
// ----------------------------------------------------------------------------
package hic_pkg;

  localparam int MAX_INDEX_W = 32;
  localparam int TOP_W       = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 5;
  localparam int PIX_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_X_BIT_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_BIT_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_WIDTH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_HEIGHT = 3'd6;

  localparam logic [COUNT_W-1:0]    RST_BIT_COUNT = 5'd1;
  localparam logic [CFG_DATA_W-1:0] RST_CELL_SIZE = 16'd1;

  typedef struct packed {
    logic [MAX_INDEX_W-1:0] xmask;
    logic [MAX_INDEX_W-1:0] ymask;
    logic [TOP_W-1:0]       top;
    logic [CFG_DATA_W-1:0]  cell_size;
    logic [CFG_DATA_W-1:0]  origin_x;
    logic [CFG_DATA_W-1:0]  origin_y;
    logic [CFG_DATA_W-1:0]  area_width;
    logic [CFG_DATA_W-1:0]  area_height;
  } cfg_t;

endpackage

FILE: rtl/hic_cfg.sv
// ----------------------------------------------------------------------------
// hic_cfg: configuration registers
// Holds the seven registers and derives the x/y bit masks and walk length.
// ----------------------------------------------------------------------------
module hic_cfg #(
  parameter int IDX_W = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [hic_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hic_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output hic_pkg::cfg_t                      cfg
);

  localparam logic [hic_pkg::COUNT_W-1:0] HALF = hic_pkg::COUNT_W'(IDX_W / 2);

  logic [hic_pkg::COUNT_W-1:0]    x_bit_count;
  logic [hic_pkg::COUNT_W-1:0]    y_bit_count;
  logic [hic_pkg::CFG_DATA_W-1:0] cell_size;
  logic [hic_pkg::CFG_DATA_W-1:0] origin_x;
  logic [hic_pkg::CFG_DATA_W-1:0] origin_y;
  logic [hic_pkg::CFG_DATA_W-1:0] area_width;
  logic [hic_pkg::CFG_DATA_W-1:0] area_height;

  logic [hic_pkg::COUNT_W-1:0] xb;
  logic [hic_pkg::COUNT_W-1:0] yb;
  logic [hic_pkg::TOP_W-1:0]   x2;
  logic [hic_pkg::TOP_W-1:0]   y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_bit_count <= hic_pkg::RST_BIT_COUNT;
      y_bit_count <= hic_pkg::RST_BIT_COUNT;
      cell_size   <= hic_pkg::RST_CELL_SIZE;
      origin_x    <= '0;
      origin_y    <= '0;
      area_width  <= '0;
      area_height <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hic_pkg::REG_X_BIT_COUNT: x_bit_count <= cfg_wdata[hic_pkg::COUNT_W-1:0];
        hic_pkg::REG_Y_BIT_COUNT: y_bit_count <= cfg_wdata[hic_pkg::COUNT_W-1:0];
        hic_pkg::REG_CELL_SIZE:   cell_size   <= cfg_wdata;
        hic_pkg::REG_ORIGIN_X:    origin_x    <= cfg_wdata;
        hic_pkg::REG_ORIGIN_Y:    origin_y    <= cfg_wdata;
        hic_pkg::REG_AREA_WIDTH:  area_width  <= cfg_wdata;
        hic_pkg::REG_AREA_HEIGHT: area_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    xb = (x_bit_count > HALF) ? HALF : x_bit_count;
    yb = (y_bit_count > HALF) ? HALF : y_bit_count;
    x2 = {xb, 1'b0};
    y2 = {yb, 1'b0};
    for (int b = 0; b < hic_pkg::MAX_INDEX_W; b++) begin
      cfg.xmask[b] = (b < IDX_W) && ((b & 1) == 1) && (hic_pkg::TOP_W'(b) < x2);
      cfg.ymask[b] = (b < IDX_W) && ((b & 1) == 0) && (hic_pkg::TOP_W'(b) < y2);
    end
    cfg.top         = (xb > yb) ? x2 : y2;
    cfg.cell_size   = cell_size;
    cfg.origin_x    = origin_x;
    cfg.origin_y    = origin_y;
    cfg.area_width  = area_width;
    cfg.area_height = area_height;
  end

endmodule

FILE: rtl/hic_walk_stage.sv
// ----------------------------------------------------------------------------
// hic_walk_stage: one register stage of the curve bit walk
// Applies up to STEPS consecutive bit positions of the invert/swap walk.
// ----------------------------------------------------------------------------
module hic_walk_stage #(
  parameter int IDX_W   = 32,
  parameter int FIRST_N = 2,
  parameter int STEPS   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  hic_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   in_g,
  output logic               in_ready,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_g,
  input  logic               out_ready
);

  localparam int IX_W = $clog2(IDX_W + 1);

  function automatic logic [IDX_W-1:0] low_mask(input int e);
    logic [IDX_W-1:0] m;
    for (int b = 0; b < IDX_W; b++) begin
      m[b] = (b <= e);
    end
    return m;
  endfunction

  logic [IDX_W-1:0] g_next;

  always_comb begin
    logic [IDX_W-1:0] g;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] xm;
    logic [IDX_W-1:0] ym;
    logic [IDX_W:0]   g_ext;
    int               n;
    g     = in_g;
    lower = '0;
    xm    = '0;
    ym    = '0;
    g_ext = '0;
    n     = 0;
    for (int j = 0; j < STEPS; j++) begin
      n = FIRST_N + j;
      if ((n <= IDX_W) && (hic_pkg::TOP_W'(n) <= cfg.top)) begin
        lower = low_mask(n & ~1);
        xm    = cfg.xmask[IDX_W-1:0] & lower;
        ym    = cfg.ymask[IDX_W-1:0] & lower;
        g_ext = {1'b0, g};
        if (g_ext[IX_W'(n)]) begin
          g = g ^ xm;
        end else if ((n & 1) == 0) begin
          g = (g & ~lower) | ((g & ym) << 1) | ((g & xm) >> 1);
        end
      end
    end
    g_next = g;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_g <= g_next;
    end
  end

endmodule

FILE: rtl/hic_scale.sv
// ----------------------------------------------------------------------------
// hic_scale: cell extraction, scaling and bounds check
// Stage 1 splits the walked bits into cell x/y and multiplies by the cell
// size; stage 2 adds the origin and checks the square against the area.
// ----------------------------------------------------------------------------
module hic_scale #(
  parameter int IDX_W = 32,
  parameter int CW    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hic_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  input  logic [IDX_W-1:0]           in_g,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CW-1:0]              cell_x,
  output logic [CW-1:0]              cell_y,
  output logic [hic_pkg::PIX_W-1:0]  pixel_x,
  output logic [hic_pkg::PIX_W-1:0]  pixel_y,
  output logic                       in_bounds
);

  localparam int GW = (IDX_W > 2 * CW) ? IDX_W : 2 * CW;
  localparam int PW = CW + hic_pkg::CFG_DATA_W;
  localparam int BW = PW + 1;

  logic [GW-1:0] gw;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;

  logic          s1_valid;
  logic          s1_ready;
  logic [CW-1:0] s1_cx;
  logic [CW-1:0] s1_cy;
  logic [PW-1:0] s1_prodx;
  logic [PW-1:0] s1_prody;

  always_comb begin
    gw = GW'(in_g);
    for (int k = 0; k < CW; k++) begin
      cx[k] = gw[2 * k + 1];
      cy[k] = gw[2 * k];
    end
  end

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cx    <= cx;
      s1_cy    <= cy;
      s1_prodx <= PW'(cx) * PW'(cfg.cell_size);
      s1_prody <= PW'(cy) * PW'(cfg.cell_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  // origin cancels on both sides of the box test
  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      cell_x    <= s1_cx;
      cell_y    <= s1_cy;
      pixel_x   <= hic_pkg::PIX_W'(cfg.origin_x) + hic_pkg::PIX_W'(s1_prodx);
      pixel_y   <= hic_pkg::PIX_W'(cfg.origin_y) + hic_pkg::PIX_W'(s1_prody);
      in_bounds <= ((BW'(s1_prodx) + BW'(cfg.cell_size)) <= BW'(cfg.area_width)) &&
                   ((BW'(s1_prody) + BW'(cfg.cell_size)) <= BW'(cfg.area_height));
    end
  end

endmodule

FILE: rtl/hilbert_index_to_cell.sv
// ----------------------------------------------------------------------------
// hilbert_index_to_cell: curve index to cell and pixel position
// Gray-codes the index, walks its bit pairs, splits x/y and scales to pixels.
// ----------------------------------------------------------------------------
// Accepts one item per clock while m_tready is high and returns one result
// per item, in order. The bit walk runs eight bit positions per register
// stage, followed by one multiply stage and one add/compare stage.
// Backpressure on m_tready stalls the whole pipe without loss; s_tready is
// high whenever m_tready is high. Register writes take effect on the next
// cycle and must only be made while no item is in flight.
module hilbert_index_to_cell #(
  parameter int INDEX_WIDTH = 32,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_wr_en,
  input  logic [hic_pkg::CFG_INDEX_W-1:0]              cfg_index,
  input  logic [hic_pkg::CFG_DATA_W-1:0]               cfg_wdata,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // curve_index
  input  logic [((INDEX_WIDTH+7)/8)*8-1:0]             s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // cell_x, cell_y, pixel_x, pixel_y, in_bounds
  output logic [((2*COORD_WIDTH+65+7)/8)*8-1:0]        m_tdata
);

  localparam int NWS   = (INDEX_WIDTH - 1 + 7) / 8;
  localparam int OUT_W = ((2 * COORD_WIDTH + 65 + 7) / 8) * 8;

  hic_pkg::cfg_t cfg;

  logic                   vld [NWS+1];
  logic                   rdy [NWS+1];
  logic [INDEX_WIDTH-1:0] gs  [NWS+1];
  logic [INDEX_WIDTH-1:0] curve_index;

  logic [COORD_WIDTH-1:0]     cell_x;
  logic [COORD_WIDTH-1:0]     cell_y;
  logic [hic_pkg::PIX_W-1:0]  pixel_x;
  logic [hic_pkg::PIX_W-1:0]  pixel_y;
  logic                       in_bounds;

  hic_cfg #(.IDX_W(INDEX_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign curve_index = s_tdata[INDEX_WIDTH-1:0];
  assign gs[0]       = curve_index ^ (curve_index >> 1);
  assign vld[0]      = s_tvalid;
  assign s_tready    = rdy[0];

  for (genvar i = 0; i < NWS; i++) begin : g_walk
    hic_walk_stage #(
      .IDX_W   (INDEX_WIDTH),
      .FIRST_N (2 + 8 * i),
      .STEPS   (8)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (vld[i]),
      .in_g      (gs[i]),
      .in_ready  (rdy[i]),
      .out_valid (vld[i+1]),
      .out_g     (gs[i+1]),
      .out_ready (rdy[i+1])
    );
  end

  hic_scale #(.IDX_W(INDEX_WIDTH), .CW(COORD_WIDTH)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (vld[NWS]),
    .in_g      (gs[NWS]),
    .in_ready  (rdy[NWS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .in_bounds (in_bounds)
  );

  assign m_tdata = OUT_W'({in_bounds, pixel_y, pixel_x, cell_y, cell_x});

endmodule

FILE: rtl/hic_checker.sv
// ----------------------------------------------------------------------------
// hic_checker: port-level checks for hilbert_index_to_cell
// Tracks items in flight and checks ordering of the stream handshakes.
// ----------------------------------------------------------------------------
module hic_checker #(
  parameter int INDEX_WIDTH = 32,
  parameter int COORD_WIDTH = 16
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tvalid,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [((2*COORD_WIDTH+65+7)/8)*8-1:0]  m_tdata
);

  localparam int DEPTH = (INDEX_WIDTH - 1 + 7) / 8 + 2;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] inflight;
  logic             s_acc;
  logic             m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(s_acc) - CNT_W'(m_acc);
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != '0)
    else $error("result shown with no item in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind hilbert_index_to_cell hic_checker #(
  .INDEX_WIDTH (INDEX_WIDTH),
  .COORD_WIDTH (COORD_WIDTH)
) u_hic_checker (.*);
